// File: hw/rtl/bfu_pkg.sv
// Shared constants, codes and types of the single-hash Bloom filter unit.
package bfu_pkg;

  localparam int WORD_W    = 64;
  localparam int WIU_W     = 11;
  localparam int KEY_W     = 32;
  localparam int HKEY_W    = 31;
  localparam int WIDX_W    = 10;
  localparam int POS_W     = 16;
  localparam int FPOS_W    = 17;
  localparam int EXT_W     = 17;
  localparam int LOW_W     = 6;
  localparam int QUO_W     = 26;
  localparam int DIV_STEPS = 26;
  localparam int DCNT_W    = 5;

  localparam int DEFAULT_MAX_WORDS = 1024;
  localparam int WIU_LIMIT         = 2047;

  localparam logic [WIU_W-1:0] WIU_RESET = 11'd1024;
  localparam logic [31:0]      HASH_MULT = 32'h045d9f3b;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_MERGE  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic REG_WIU = 1'b0;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_cmd_t;

endpackage

// File: hw/rtl/single_hash_bloom_filter_unit.sv
// Single-hash Bloom filter unit: request control, config register and result word.
// Insert/query: accept, 1 multiply and 26 remainder steps in bfu_hash, done, memory read,
//   modify/write, result word; merge skips the hash; rejected merge or unused go to the result.
// One request at a time (serial remainder loop); the next accept can follow in the
//   cycle after the result load.
// Reset: synchronous, active low; words_in_use returns to 1024, then the store is
//   cleared one word per cycle, all MAX_WORDS words, with in_ready held low.
module single_hash_bloom_filter_unit #(
  parameter int MAX_WORDS = bfu_pkg::DEFAULT_MAX_WORDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic signed [bfu_pkg::KEY_W-1:0] in_key,
  input  logic [bfu_pkg::WIDX_W-1:0]    in_word_index,
  input  logic [bfu_pkg::WORD_W-1:0]    in_merge_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [bfu_pkg::POS_W-1:0]     out_bit_position,
  output logic                          out_index_error,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CLAMP_I = (MAX_WORDS > bfu_pkg::WIU_LIMIT) ? bfu_pkg::WIU_LIMIT : MAX_WORDS;
  localparam logic [bfu_pkg::WIU_W-1:0] CLAMP = CLAMP_I[bfu_pkg::WIU_W-1:0];

  // Control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                   state_r;
  logic [bfu_pkg::WIU_W-1:0]    wiu_r;
  logic [1:0]                   req_r;
  logic [bfu_pkg::WORD_W-1:0]   mword_r;
  logic [AW-1:0]                addr_r;
  logic [bfu_pkg::FPOS_W-1:0]   pos_r;
  logic                         err_r;

  logic                         out_valid_r;
  logic                         hit_r;
  logic [bfu_pkg::POS_W-1:0]    bitpos_r;
  logic                         ierr_r;

  logic [bfu_pkg::WIU_W-1:0]    eff_words;
  logic                         accept;
  logic                         merge_ok;
  logic                         finish;
  logic                         hash_start;
  logic                         hash_done;
  logic [bfu_pkg::FPOS_W-1:0]   hash_pos;
  logic [bfu_pkg::EXT_W-1:0]    hash_ext;
  logic [bfu_pkg::EXT_W-1:0]    widx_ext;
  logic [bfu_pkg::EXT_W-1:0]    addr_ext;
  logic                         clr_busy;
  logic [bfu_pkg::WORD_W-1:0]   rd_data;
  logic [bfu_pkg::WORD_W-1:0]   bit_mask;
  logic [bfu_pkg::WORD_W-1:0]   wr_data;
  bfu_pkg::store_cmd_t          st_cmd;
  logic                         is_key;

  // Config register: a zero count acts as one word, a count above the store depth
  // acts as the full depth.
  always_comb begin
    if (wiu_r == '0) begin
      eff_words = bfu_pkg::WIU_W'(1);
    end else if (wiu_r > CLAMP) begin
      eff_words = CLAMP;
    end else begin
      eff_words = wiu_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiu_r <= bfu_pkg::WIU_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == bfu_pkg::REG_WIU) begin
      wiu_r <= pwdata[bfu_pkg::WIU_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bfu_pkg::REG_WIU) ? {21'd0, wiu_r} : 32'd0;

  // Accept only when idle and the store sweep is over.
  assign in_ready   = (state_r == ST_IDLE) && !clr_busy;
  assign accept     = in_valid && in_ready;
  assign merge_ok   = {1'b0, in_word_index} < eff_words;
  assign hash_start = accept && (in_req_type == bfu_pkg::REQ_INSERT ||
                                 in_req_type == bfu_pkg::REQ_QUERY);

  assign hash_ext = bfu_pkg::EXT_W'(hash_pos[bfu_pkg::FPOS_W-1:bfu_pkg::LOW_W]);
  assign widx_ext = bfu_pkg::EXT_W'(in_word_index);
  assign addr_ext = bfu_pkg::EXT_W'(addr_r);

  // Retire the word only when the result register is free or being drained.
  assign finish = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign is_key = (req_r == bfu_pkg::REQ_INSERT) || (req_r == bfu_pkg::REQ_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_req_type)
              bfu_pkg::REQ_INSERT, bfu_pkg::REQ_QUERY: state_r <= ST_HASH;
              bfu_pkg::REQ_MERGE: state_r <= merge_ok ? ST_READ : ST_DONE;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: state_r <= ST_DONE;
        ST_DONE: begin
          if (finish) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Hold request payload for the whole item.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      mword_r <= in_merge_word;
      addr_r  <= widx_ext[AW-1:0];
      pos_r   <= '0;
      err_r   <= (in_req_type == bfu_pkg::REQ_MERGE) && !merge_ok;
    end else if (state_r == ST_HASH && hash_done) begin
      addr_r <= hash_ext[AW-1:0];
      pos_r  <= hash_pos;
    end
  end

  bfu_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .key_low (in_key[bfu_pkg::HKEY_W-1:0]),
    .n_words (eff_words),
    .done    (hash_done),
    .pos     (hash_pos)
  );

  // Read in ST_READ; modify and write back as the item retires.
  assign bit_mask = bfu_pkg::WORD_W'(1) << pos_r[bfu_pkg::LOW_W-1:0];
  assign wr_data  = (req_r == bfu_pkg::REQ_MERGE) ? (rd_data | mword_r) : (rd_data | bit_mask);

  always_comb begin
    st_cmd.rd_en = (state_r == ST_READ);
    st_cmd.wr_en = finish && ((req_r == bfu_pkg::REQ_INSERT) ||
                              (req_r == bfu_pkg::REQ_MERGE && !err_r));
  end

  bfu_store #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (st_cmd),
    .addr     (addr_r),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  // Result register: loads on retire, drops on handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit_r    <= (req_r == bfu_pkg::REQ_QUERY) && ((rd_data & bit_mask) != '0);
      bitpos_r <= is_key ? pos_r[bfu_pkg::POS_W-1:0] : '0;
      ierr_r   <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_bit_position = bitpos_r;
  assign out_index_error  = ierr_r;

  // An accepted word closes the input until it retires.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("in_ready stayed high after accept");

  // The hash unit only reports while a key request waits on it.
  a_hash_owner: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> state_r == ST_HASH)
    else $error("hash done outside hash wait");

  // No write lands at or beyond the words in use.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_cmd.wr_en |-> addr_ext < bfu_pkg::EXT_W'(eff_words))
    else $error("store write beyond words in use");

  // A new result word appears only from a retiring item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word without a retiring item");

endmodule

// File: hw/rtl/bfu_hash.sv
// Iterative key hash: xor-shift, multiply, xor-shift, then remainder by 64 * words in use.
module bfu_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bfu_pkg::HKEY_W-1:0]   key_low,
  input  logic [bfu_pkg::WIU_W-1:0]    n_words,
  output logic                         done,
  output logic [bfu_pkg::FPOS_W-1:0]   pos
);

  localparam logic [1:0] HS_IDLE = 2'd0;
  localparam logic [1:0] HS_MUL  = 2'd1;
  localparam logic [1:0] HS_DIV  = 2'd2;

  logic [1:0]                        state_r;
  logic [bfu_pkg::HKEY_W-1:0]        h1_r;
  logic [bfu_pkg::QUO_W-1:0]         quo_r;
  logic [bfu_pkg::LOW_W-1:0]         low_r;
  logic [bfu_pkg::WIU_W-1:0]         rem_r;
  logic [bfu_pkg::DCNT_W-1:0]        cnt_r;
  logic                              done_r;

  logic [31:0]                       prod;
  logic [31:0]                       h2;
  logic [bfu_pkg::WIU_W:0]           trial;
  logic                              fits;
  logic [bfu_pkg::WIU_W:0]           diff;
  logic [bfu_pkg::WIU_W-1:0]         rem_nxt;

  assign prod    = {1'b0, h1_r} * bfu_pkg::HASH_MULT;
  assign h2      = prod ^ {16'd0, prod[31:16]};
  // Restoring remainder step: shift in next dividend bit, subtract when it fits.
  assign trial   = {rem_r, quo_r[bfu_pkg::QUO_W-1]};
  assign fits    = trial >= {1'b0, n_words};
  assign diff    = trial - {1'b0, n_words};
  assign rem_nxt = fits ? diff[bfu_pkg::WIU_W-1:0] : trial[bfu_pkg::WIU_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        HS_IDLE: begin
          if (start) begin
            state_r <= HS_MUL;
          end
        end
        HS_MUL: begin
          cnt_r   <= '0;
          state_r <= HS_DIV;
        end
        HS_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == bfu_pkg::DCNT_W'(bfu_pkg::DIV_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= HS_IDLE;
          end
        end
        default: state_r <= HS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == HS_IDLE && start) begin
      h1_r <= key_low ^ {16'd0, key_low[bfu_pkg::HKEY_W-1:16]};
    end
    if (state_r == HS_MUL) begin
      quo_r <= h2[31:bfu_pkg::LOW_W];
      low_r <= h2[bfu_pkg::LOW_W-1:0];
      rem_r <= '0;
    end
    if (state_r == HS_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[bfu_pkg::QUO_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign pos  = {rem_r, low_r};

endmodule

// File: hw/rtl/bfu_store.sv
// Filter word memory with registered read and a clearing sweep after reset.
module bfu_store #(
  parameter int DEPTH = bfu_pkg::DEFAULT_MAX_WORDS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfu_pkg::store_cmd_t         cmd,
  input  logic [AW-1:0]               addr,
  input  logic [bfu_pkg::WORD_W-1:0]  wr_data,
  output logic [bfu_pkg::WORD_W-1:0]  rd_data,
  output logic                        clr_busy
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [bfu_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bfu_pkg::WORD_W-1:0] rd_r;
  logic [AW-1:0]              clr_addr_r;
  logic                       clr_busy_r;

  logic                       we;
  logic [AW-1:0]              wa;
  logic [bfu_pkg::WORD_W-1:0] wd;

  assign we = clr_busy_r | cmd.wr_en;
  assign wa = clr_busy_r ? clr_addr_r : addr;
  assign wd = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  assign rd_data  = rd_r;
  assign clr_busy = clr_busy_r;

endmodule
